// ===== rtl/pip_pkg.sv =====
// Shared types and widths for the point-in-polygon crossing test.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	// Coordinate widths
	localparam int XW  = 32;       // x coordinate
	localparam int YW  = 31;       // y coordinate
	localparam int DXW = XW + 1;   // x difference
	localparam int DYW = YW + 1;   // y difference
	localparam int PW  = DXW + DYW; // exact slope product

	// Position of the query point against both ends of one edge
	typedef struct packed {
		logic above1;
		logic above2;
		logic right1;
		logic right2;
	} edge_flags_t;

	// Load strobes for the edge pipeline stages s1 and s2
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
	} pipe_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/point_in_polygon_crossing_test.sv =====
// Top level of the point-in-polygon crossing parity test.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------------------
//   in       | input     | in_valid / in_ready   | query_x query_y vert_x vert_y first/last
//   out      | output    | out_valid / out_ready | inside_res (one item per last vertex)
//
// One vertex item is taken per cycle while in_ready is high. Each item runs
// the edge slices u_edge_a and u_edge_b in parallel (prior->vertex and, for a last vertex,
// vertex->start), passing from acceptance to a visible result through a
// difference stage, a product stage, then compare plus parity update into the output register.
// Reset (arst_n low) empties the pipeline and zeroes point, start, prior
// and parity. A held result stalls the pipeline only once a last-marked
// item reaches the compare stage; vertices ahead of it keep flowing into
// the parity register.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_crossing_test (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [pip_pkg::XW-1:0] query_x,
	input  logic signed [pip_pkg::YW-1:0] query_y,
	input  logic signed [pip_pkg::XW-1:0] vert_x,
	input  logic signed [pip_pkg::YW-1:0] vert_y,
	input  logic                          first_vertex,
	input  logic                          last_vertex,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          inside_res
);

	// Ring state, updated at acceptance
	logic signed [pip_pkg::XW-1:0] point_x_q, start_x_q, prior_x_q;
	logic signed [pip_pkg::YW-1:0] point_y_q, start_y_q, prior_y_q;

	// Pipeline valid bits and item marks
	logic v_s1, v_s2;
	logic first_s1, last_s1, first_s2, last_s2;

	logic parity_q;
	logic out_valid_q;
	logic inside_q;

	logic in_fire;
	logic out_free;
	logic go1, go2;
	logic ready1, ready2;
	pip_pkg::pipe_ctl_t ctl;

	logic cross_a, cross_b;
	logic par_next;

	// Closing edge operands: a first vertex closes onto itself
	logic signed [pip_pkg::XW-1:0] cls_px, cls_x2;
	logic signed [pip_pkg::YW-1:0] cls_py, cls_y2;

	// Elastic handshake: each stage moves when the next one has room
	assign out_free = !out_valid_q || out_ready;
	assign go2      = v_s2 && (!last_s2 || out_free);
	assign ready2   = !v_s2 || go2;
	assign go1      = v_s1 && ready2;
	assign ready1   = !v_s1 || go1;
	assign in_ready = ready1;
	assign in_fire  = in_valid && ready1;

	assign ctl.ld_s1 = in_fire;
	assign ctl.ld_s2 = go1;

	assign cls_px = first_vertex ? query_x : point_x_q;
	assign cls_py = first_vertex ? query_y : point_y_q;
	assign cls_x2 = first_vertex ? vert_x : start_x_q;
	assign cls_y2 = first_vertex ? vert_y : start_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q <= '0;
			point_y_q <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
			prior_x_q <= '0;
			prior_y_q <= '0;
		end else if (in_fire) begin
			if (first_vertex) begin
				point_x_q <= query_x;
				point_y_q <= query_y;
				start_x_q <= vert_x;
				start_y_q <= vert_y;
			end
			prior_x_q <= vert_x;
			prior_y_q <= vert_y;
		end
	end

	// Edge from the previous vertex to this one (ignored on a first vertex)
	pip_edge_slice u_edge_a (
		.clk      (clk),
		.ctl      (ctl),
		.px       (point_x_q),
		.py       (point_y_q),
		.x1       (prior_x_q),
		.y1       (prior_y_q),
		.x2       (vert_x),
		.y2       (vert_y),
		.crossing (cross_a)
	);

	// Closing edge from this vertex back to the start (used on a last vertex)
	pip_edge_slice u_edge_b (
		.clk      (clk),
		.ctl      (ctl),
		.px       (cls_px),
		.py       (cls_py),
		.x1       (vert_x),
		.y1       (vert_y),
		.x2       (cls_x2),
		.y2       (cls_y2),
		.crossing (cross_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready1) begin
				v_s1 <= in_fire;
			end
			if (ready2) begin
				v_s2 <= go1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			first_s1 <= first_vertex;
			last_s1  <= last_vertex;
		end
		if (go1) begin
			first_s2 <= first_s1;
			last_s2  <= last_s1;
		end
	end

	// First vertex restarts parity; closing edge toggles on top of it
	assign par_next = (first_s2 ? 1'b0 : (parity_q ^ cross_a)) ^ (last_s2 & cross_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go2) begin
				parity_q <= par_next;
			end
			if (go2 && last_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go2 && last_s2) begin
			inside_q <= par_next;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;

endmodule

`default_nettype wire

// ===== rtl/pip_edge_slice.sv =====
// One edge crossing test: differences, exact slope products, compare.
`timescale 1ns / 1ps
`default_nettype none

module pip_edge_slice (
	input  logic                                clk,
	input  pip_pkg::pipe_ctl_t                  ctl,
	input  logic signed [pip_pkg::XW-1:0]       px,
	input  logic signed [pip_pkg::YW-1:0]       py,
	input  logic signed [pip_pkg::XW-1:0]       x1,
	input  logic signed [pip_pkg::YW-1:0]       y1,
	input  logic signed [pip_pkg::XW-1:0]       x2,
	input  logic signed [pip_pkg::YW-1:0]       y2,
	output logic                                crossing
);

	logic signed [pip_pkg::DXW-1:0] pxe, x1e, x2e;
	logic signed [pip_pkg::DYW-1:0] pye, y1e, y2e;

	logic signed [pip_pkg::DYW-1:0] dy_s1;    // y2 - py
	logic signed [pip_pkg::DXW-1:0] dx_s1;    // x2 - x1
	logic signed [pip_pkg::DYW-1:0] dy12_s1;  // y2 - y1
	logic signed [pip_pkg::DXW-1:0] dxp_s1;   // x2 - px
	pip_pkg::edge_flags_t           flags_s1;

	logic signed [pip_pkg::PW-1:0]  p1_s2;
	logic signed [pip_pkg::PW-1:0]  p2_s2;
	pip_pkg::edge_flags_t           flags_s2;

	assign pxe = $signed({px[pip_pkg::XW-1], px});
	assign x1e = $signed({x1[pip_pkg::XW-1], x1});
	assign x2e = $signed({x2[pip_pkg::XW-1], x2});
	assign pye = $signed({py[pip_pkg::YW-1], py});
	assign y1e = $signed({y1[pip_pkg::YW-1], y1});
	assign y2e = $signed({y2[pip_pkg::YW-1], y2});

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			dy_s1           <= y2e - pye;
			dx_s1           <= x2e - x1e;
			dy12_s1         <= y2e - y1e;
			dxp_s1          <= x2e - pxe;
			flags_s1.above1 <= py > y1;
			flags_s1.above2 <= py > y2;
			flags_s1.right1 <= px <= x1;
			flags_s1.right2 <= px <= x2;
		end
	end

	// two 32x33 signed products, exact in 65 bits
	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			p1_s2 <= $signed({{(pip_pkg::PW-pip_pkg::DYW){dy_s1[pip_pkg::DYW-1]}}, dy_s1})
				* $signed({{(pip_pkg::PW-pip_pkg::DXW){dx_s1[pip_pkg::DXW-1]}}, dx_s1});
			p2_s2 <= $signed({{(pip_pkg::PW-pip_pkg::DYW){dy12_s1[pip_pkg::DYW-1]}}, dy12_s1})
				* $signed({{(pip_pkg::PW-pip_pkg::DXW){dxp_s1[pip_pkg::DXW-1]}}, dxp_s1});
			flags_s2 <= flags_s1;
		end
	end

	// equal slopes count as a crossing (boundary is inside)
	always_comb begin
		priority if (flags_s2.above1 == flags_s2.above2) begin
			crossing = 1'b0;
		end else if (!flags_s2.right1 && !flags_s2.right2) begin
			crossing = 1'b0;
		end else if (flags_s2.right1 && flags_s2.right2) begin
			crossing = 1'b1;
		end else if (flags_s2.above1) begin
			crossing = p1_s2 <= p2_s2;
		end else begin
			crossing = p1_s2 >= p2_s2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pip_checker.sv =====
// Port-level checker for the crossing test, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pip_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic last_vertex,
	input logic out_valid,
	input logic out_ready,
	input logic inside_res
);

	// last-marked items accepted but not yet delivered
	logic [2:0] pend_q;
	logic       take_last;
	logic       give;

	assign take_last = in_valid && in_ready && last_vertex;
	assign give      = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 3'(take_last) - 3'(give);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(inside_res))
		else $error("held result dropped or changed");

	a_in_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> in_ready)
		else $error("input stalled with no last vertex in flight");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("result without a last vertex");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd3)
		else $error("more results in flight than pipeline holds");

endmodule

bind point_in_polygon_crossing_test pip_checker u_pip_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.last_vertex (last_vertex),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.inside_res  (inside_res)
);

`default_nettype wire
